@@ hw/rtl/diacritic_fold_tag_strip_top_assert.svh @@
// Assertion macros for the diacritic fold / tag strip block.
`ifndef DIACRITIC_FOLD_TAG_STRIP_TOP_ASSERT_SVH
`define DIACRITIC_FOLD_TAG_STRIP_TOP_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define DFTS_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define DFTS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DFTS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/dfts_pkg.sv @@
// Types, constants and lookup functions for the diacritic fold / tag strip block.
`default_nettype none

package dfts_pkg;

    // Markup delimiters
    localparam logic [7:0] CH_OPEN  = 8'h3C;
    localparam logic [7:0] CH_CLOSE = 8'h3E;

    // Range of UTF-8 lead bytes that can start a folded letter
    localparam logic [7:0] LEAD_LO = 8'hC3;
    localparam logic [7:0] LEAD_HI = 8'hC5;

    // Result queue geometry
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_char;
        logic       out_last;
    } out_item_t;

    typedef struct packed {
        logic       in_markup;
        logic [7:0] held_byte;
        logic       held_valid;
    } state_t;

    // Up to two results from one input transaction
    typedef struct packed {
        logic [1:0] n;
        out_item_t  res0;
        out_item_t  res1;
    } step_res_t;

    typedef struct packed {
        logic [QCNT_W-1:0] level;
    } q_stat_t;

    function automatic logic [7:0] lower_ascii(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A)
            r = b + 8'h20;
        return r;
    endfunction

    function automatic logic is_lead(input logic [7:0] b);
        return (b >= LEAD_LO) && (b <= LEAD_HI);
    endfunction

    // Folded ASCII letter for a two-byte sequence, zero when not a known letter
    function automatic logic [7:0] fold_pair(input logic [7:0] lead, input logic [7:0] cont);
        logic [7:0] r;
        case ({lead, cont})
            16'hC4BE, 16'hC4BA, 16'hC4BD, 16'hC4B9: r = "l";
            16'hC5A1, 16'hC5A0:                     r = "s";
            16'hC48D, 16'hC48C:                     r = "c";
            16'hC5A5, 16'hC5A4:                     r = "t";
            16'hC5BE, 16'hC5BD:                     r = "z";
            16'hC3BD, 16'hC39D:                     r = "y";
            16'hC3A1, 16'hC3A4, 16'hC381, 16'hC384: r = "a";
            16'hC3A9, 16'hC49B, 16'hC389, 16'hC49A: r = "e";
            16'hC3AD, 16'hC38D:                     r = "i";
            16'hC3B3, 16'hC3B4, 16'hC393, 16'hC394: r = "o";
            16'hC3BA, 16'hC39A:                     r = "u";
            16'hC48F, 16'hC48E:                     r = "d";
            16'hC588, 16'hC587:                     r = "n";
            16'hC599, 16'hC598:                     r = "r";
            default:                                r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/dfts_step.sv @@
// Per-byte normalization logic: pair folding, markup tracking, end-of-string flush.
`default_nettype none

module dfts_step
    import dfts_pkg::*;
(
    input  state_t    state,
    input  in_item_t  item,
    output state_t    state_next,
    output step_res_t res
);

    logic [7:0] b;
    logic [7:0] folded;
    logic       hit;
    logic       markup_n;
    logic       hold_n;
    logic       p0_valid;
    logic       p1_valid;
    logic       p2_valid;
    logic       bare;
    logic [7:0] p0;
    logic [7:0] p1;

    // Pair lookup and markup / hold decisions
    always_comb
    begin
        b        = item.in_byte;
        folded   = fold_pair(state.held_byte, b);
        hit      = state.held_valid && (folded != 8'h00);
        markup_n = state.in_markup;
        if (!hit && b == CH_OPEN)
            markup_n = 1'b1;
        if (!hit && b == CH_CLOSE)
            markup_n = 1'b0;
        hold_n   = !hit && !markup_n && is_lead(b);

        // Candidate results in emission order
        p0_valid = state.held_valid;
        p0       = hit ? folded : lower_ascii(state.held_byte);
        p1_valid = !hit && !markup_n && !is_lead(b);
        p1       = lower_ascii(b);
        p2_valid = item.in_last && hold_n;
        bare     = item.in_last && !p0_valid && !p1_valid && !p2_valid;
    end

    // Pack results into two slots
    always_comb
    begin
        res = '0;
        if (p0_valid)
        begin
            res.res0.out_byte = p0;
            res.res0.has_char = 1'b1;
            if (p1_valid || p2_valid)
            begin
                res.n             = 2'd2;
                res.res1.out_byte = p1_valid ? p1 : b;
                res.res1.has_char = 1'b1;
                res.res1.out_last = item.in_last;
            end
            else
            begin
                res.n             = 2'd1;
                res.res0.out_last = item.in_last;
            end
        end
        else if (p1_valid || p2_valid)
        begin
            res.n             = 2'd1;
            res.res0.out_byte = p1_valid ? p1 : b;
            res.res0.has_char = 1'b1;
            res.res0.out_last = item.in_last;
        end
        else if (bare)
        begin
            res.n             = 2'd1;
            res.res0.out_last = 1'b1;
        end
    end

    // Next state; end of string returns to the reset state
    always_comb
    begin
        if (item.in_last)
        begin
            state_next = '0;
        end
        else
        begin
            state_next.in_markup  = markup_n;
            state_next.held_byte  = hold_n ? b : 8'h00;
            state_next.held_valid = hold_n;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/dfts_outq.sv @@
// Result queue: takes up to two results per cycle, delivers one per transaction.
`default_nettype none

module dfts_outq
    import dfts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic [1:0] push_n,
    input  out_item_t push0,
    input  out_item_t push1,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data,
    output q_stat_t   stat
);

    out_item_t         mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              pop;

    assign out_valid  = (cnt_reg != '0);
    assign out_data   = mem_reg[rd_ptr_reg];
    assign pop        = out_valid && out_ready;
    assign stat.level = cnt_reg;

    // Pointer and fill level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        cnt_next    = cnt_reg + QCNT_W'(push_n) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Result storage
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            mem_reg[wr_ptr_reg] <= push0;
        if (push_n == 2'd2)
            mem_reg[wr_ptr_reg + QPTR_W'(1)] <= push1;
    end

endmodule

`default_nettype wire

@@ hw/rtl/diacritic_fold_tag_strip_top.sv @@
// Top level of the diacritic fold / tag strip search normalizer.
// Takes one string byte per transaction and accepts a new byte every cycle
// while in_ready is high; a byte's results enter the result queue as it is taken.
// Most bytes give one result, bytes inside markup and held lead bytes give none,
// and the byte after a lead byte that it does not pair with gives two; results
// leave one per cycle while out_ready is high through a four-entry result queue,
// so in_ready drops only while that queue holds more than two results. Sustained
// rate is one byte per cycle while out_ready is high and bytes average one result or less.
`default_nettype none

`include "diacritic_fold_tag_strip_top_assert.svh"

module diacritic_fold_tag_strip_top
    import dfts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    state_t     state_reg;
    state_t     state_next;
    state_t     step_state;
    step_res_t  step_res;
    q_stat_t    q_stat;
    logic       in_fire;
    logic [1:0] push_n;

    // Accept while the queue has room for two results
    assign in_ready = (q_stat.level <= QCNT_W'(QDEPTH - 2));
    assign in_fire  = in_valid && in_ready;
    assign push_n   = in_fire ? step_res.n : 2'd0;

    dfts_step u_step (
        .state      (state_reg),
        .item       (in_data),
        .state_next (step_state),
        .res        (step_res)
    );

    // Stream state
    always_comb
    begin
        state_next = in_fire ? step_state : state_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else
            state_reg <= state_next;
    end

    dfts_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (push_n),
        .push0     (step_res.res0),
        .push1     (step_res.res1),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .stat      (q_stat)
    );

    // Checks
    `DFTS_ASSERT(a_q_level, q_stat.level <= QCNT_W'(QDEPTH), "result queue overflow")
    `DFTS_ASSERT_IMP(a_last_res, in_fire && in_data.in_last, step_res.n != 2'd0,
        "end of string produced no result")
    `DFTS_ASSERT_NXT(a_last_clr, in_fire && in_data.in_last,
        !state_reg.held_valid && !state_reg.in_markup, "state not cleared after end of string")
    `DFTS_ASSERT_IMP(a_held_lead, state_reg.held_valid, is_lead(state_reg.held_byte),
        "held byte is not a lead byte")

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for the diacritic fold / tag strip normalizer.
`default_nettype none

module testbench;
    import dfts_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int RST_CYCLES  = 9;
    localparam int CYCLE_LIMIT = 150000;
    localparam int HOLD_CYCLES = 120;
    localparam int DRAIN_WAIT  = 8;
    localparam int PHASE_ITEMS = 206;
    localparam int DIR_ROWS    = 26;

    // One directed row: input byte, optional hand-written expectation
    typedef struct packed {
        logic [7:0] b;
        logic       last;
        logic       known;
        logic [1:0] n;
        out_item_t  r0;
        out_item_t  r1;
    } dir_row_t;

    localparam out_item_t NO_RES = '0;

    localparam dir_row_t DIR_TBL [DIR_ROWS] = '{
        // case extremes of the A-Z range and the bytes just outside it
        '{8'h41, 1'b0, 1'b1, 2'd1, '{8'h61, 1'b1, 1'b0}, NO_RES},
        '{8'h5A, 1'b0, 1'b1, 2'd1, '{8'h7A, 1'b1, 1'b0}, NO_RES},
        '{8'h40, 1'b0, 1'b1, 2'd1, '{8'h40, 1'b1, 1'b0}, NO_RES},
        '{8'h5B, 1'b0, 1'b1, 2'd1, '{8'h5B, 1'b1, 1'b0}, NO_RES},
        // zero byte and top byte pass through
        '{8'h00, 1'b0, 1'b1, 2'd1, '{8'h00, 1'b1, 1'b0}, NO_RES},
        '{8'hFF, 1'b0, 1'b1, 2'd1, '{8'hFF, 1'b1, 1'b0}, NO_RES},
        // folded pair
        '{8'hC4, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
        '{8'hBE, 1'b0, 1'b1, 2'd1, '{8'h6C, 1'b1, 1'b0}, NO_RES},
        // lead byte followed by a plain letter
        '{8'hC5, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{8'h41, 1'b0, 1'b1, 2'd2, '{8'hC5, 1'b1, 1'b0}, '{8'h61, 1'b1, 1'b0}},
        // markup dropped, closing bracket kept
        '{8'h3C, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
        '{8'h42, 1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
        '{8'h3E, 1'b0, 1'b1, 2'd1, '{8'h3E, 1'b1, 1'b0}, NO_RES},
        // lead after lead, then a pair
        '{8'hC3, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{8'hC3, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{8'h81, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        // bytes just outside the lead range
        '{8'hC2, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{8'hC6, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        // held lead flushed at end of string
        '{8'hC3, 1'b1, 1'b1, 2'd1, '{8'hC3, 1'b1, 1'b1}, NO_RES},
        // string of one open bracket: bare end marker
        '{8'h3C, 1'b1, 1'b1, 2'd1, '{8'h00, 1'b0, 1'b1}, NO_RES},
        // lead broken by markup, markup left open to the end
        '{8'hC5, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{8'h3C, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{8'h78, 1'b1, 1'b1, 2'd1, '{8'h00, 1'b0, 1'b1}, NO_RES},
        // fresh string after end: pair then last plain byte
        '{8'hC5, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{8'h98, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{8'h7A, 1'b1, 1'b0, 2'd0, NO_RES, NO_RES}
    };

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    // Predictor state
    logic       tag_open;
    logic [7:0] held_lead;
    logic       held_ok;

    out_item_t  pending_chars [$];
    logic [7:0] text_q [$];
    int         bad_cnt;
    int         cycle_cnt;
    int         send_idle_pct;
    int         recv_stall_pct;
    logic       hold_req;
    logic       hold_off;

    diacritic_fold_tag_strip_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Clock
    initial clk = 1'b0;
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Letter for an accented two-byte sequence, zero when not foldable
    function automatic logic [7:0] accent_letter(input logic [7:0] lead,
                                                 input logic [7:0] cont);
        logic [7:0] letter;
        letter = 8'h00;
        case (lead)
            8'hC3:
                case (cont)
                    8'h81, 8'h84, 8'hA1, 8'hA4: letter = "a";
                    8'h89, 8'hA9:               letter = "e";
                    8'h8D, 8'hAD:               letter = "i";
                    8'h93, 8'h94, 8'hB3, 8'hB4: letter = "o";
                    8'h9A, 8'hBA:               letter = "u";
                    8'h9D, 8'hBD:               letter = "y";
                    default:                    letter = 8'h00;
                endcase
            8'hC4:
                case (cont)
                    8'h8C, 8'h8D:               letter = "c";
                    8'h8E, 8'h8F:               letter = "d";
                    8'h9A, 8'h9B:               letter = "e";
                    8'hB9, 8'hBA, 8'hBD, 8'hBE: letter = "l";
                    default:                    letter = 8'h00;
                endcase
            8'hC5:
                case (cont)
                    8'h87, 8'h88:               letter = "n";
                    8'h98, 8'h99:               letter = "r";
                    8'hA0, 8'hA1:               letter = "s";
                    8'hA4, 8'hA5:               letter = "t";
                    8'hBD, 8'hBE:               letter = "z";
                    default:                    letter = 8'h00;
                endcase
            default: letter = 8'h00;
        endcase
        return letter;
    endfunction

    function automatic out_item_t char_res(input logic [7:0] c);
        out_item_t r;
        r.out_byte = (c >= "A" && c <= "Z") ? c + 8'h20 : c;
        r.has_char = 1'b1;
        r.out_last = 1'b0;
        return r;
    endfunction

    // Normalize one byte: updates predictor state, returns 0..2 results
    task automatic normalize_byte(input in_item_t it, output int n,
                                  output out_item_t r0, output out_item_t r1);
        out_item_t  res [2];
        logic [7:0] b;
        logic [7:0] letter;
        logic       used;
        int         cnt;
        b      = it.in_byte;
        cnt    = 0;
        used   = 1'b0;
        res[0] = '0;
        res[1] = '0;
        // held lead: try the pair first
        if (held_ok)
        begin
            letter  = accent_letter(held_lead, b);
            held_ok = 1'b0;
            if (letter != 8'h00)
            begin
                res[cnt] = char_res(letter);
                used     = 1'b1;
            end
            else
                res[cnt] = char_res(held_lead);
            cnt++;
            held_lead = 8'h00;
        end
        if (!used)
        begin
            if (b == CH_OPEN)
                tag_open = 1'b1;
            if (b == CH_CLOSE)
                tag_open = 1'b0;
            if (!tag_open)
            begin
                if (b >= LEAD_LO && b <= LEAD_HI)
                begin
                    held_lead = b;
                    held_ok   = 1'b1;
                end
                else
                begin
                    res[cnt] = char_res(b);
                    cnt++;
                end
            end
        end
        // end of string: flush, mark, restart
        if (it.in_last)
        begin
            if (held_ok)
            begin
                res[cnt] = char_res(held_lead);
                cnt++;
            end
            if (cnt == 0)
            begin
                res[0] = '0;
                cnt    = 1;
            end
            res[cnt-1].out_last = 1'b1;
            tag_open  = 1'b0;
            held_lead = 8'h00;
            held_ok   = 1'b0;
        end
        n  = cnt;
        r0 = res[0];
        r1 = res[1];
    endtask

    // Present one byte and wait for its transaction
    task automatic offer_byte(input in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic queue_results(input int n, input out_item_t r0, input out_item_t r1);
        if (n > 0)
            pending_chars.push_back(r0);
        if (n > 1)
            pending_chars.push_back(r1);
    endtask

    // Random string, mostly letters, accented pairs and markup
    task automatic random_text();
        int         len;
        int         kind;
        int         k;
        logic [7:0] lead;
        logic [7:0] cont;
        text_q.delete();
        len = $urandom_range(1, 12);
        while (text_q.size() < len)
        begin
            kind = $urandom_range(99);
            if (kind < 30)
                text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
            else if (kind < 55)
            begin
                do
                begin
                    lead = 8'($urandom_range(LEAD_LO, LEAD_HI));
                    cont = 8'($urandom_range(8'h80, 8'hBF));
                end
                while (accent_letter(lead, cont) == 8'h00);
                text_q.push_back(lead);
                text_q.push_back(cont);
            end
            else if (kind < 65)
                text_q.push_back(8'($urandom_range(LEAD_LO, LEAD_HI)));
            else if (kind < 75)
            begin
                text_q.push_back(CH_OPEN);
                k = $urandom_range(0, 4);
                repeat (k) text_q.push_back(8'($urandom_range(0, 255)));
                if ($urandom_range(3) != 0)
                    text_q.push_back(CH_CLOSE);
            end
            else if (kind < 90)
                text_q.push_back(8'($urandom_range(0, 255)));
            else if (kind < 95)
            begin
                // lead followed by an arbitrary byte, usually no match
                text_q.push_back(8'($urandom_range(LEAD_LO, LEAD_HI)));
                text_q.push_back(8'($urandom_range(0, 255)));
            end
            else
                text_q.push_back($urandom_range(1) ? CH_OPEN : CH_CLOSE);
        end
    endtask

    // Random strings under one idling mix
    task automatic run_phase(input int send_pct, input int recv_pct, input int items);
        in_item_t  it;
        out_item_t r0;
        out_item_t r1;
        int        n;
        int        sent;
        send_idle_pct = send_pct;
        recv_stall_pct <= recv_pct;
        sent = 0;
        while (sent < items)
        begin
            random_text();
            for (int i = 0; i < text_q.size(); i++)
            begin
                it.in_byte = text_q[i];
                it.in_last = (i == text_q.size() - 1);
                normalize_byte(it, n, r0, r1);
                queue_results(n, r0, r1);
                offer_byte(it);
                sent++;
            end
        end
    endtask

    // Long receiver hold-off, counted here
    initial
    begin
        hold_off = 1'b0;
        wait (hold_req);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Output monitor and receiver stalls
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_chars.size() == 0)
            begin
                $error("result with none expected: out_byte %h has_char %b out_last %b",
                       out_data.out_byte, out_data.has_char, out_data.out_last);
                bad_cnt++;
            end
            else
            begin
                want = pending_chars.pop_front();
                if (out_data.out_byte !== want.out_byte)
                begin
                    $error("out_byte expected %h actual %h",
                           want.out_byte, out_data.out_byte);
                    bad_cnt++;
                end
                if (out_data.has_char !== want.has_char)
                begin
                    $error("has_char expected %b actual %b",
                           want.has_char, out_data.has_char);
                    bad_cnt++;
                end
                if (out_data.out_last !== want.out_last)
                begin
                    $error("out_last expected %b actual %b",
                           want.out_last, out_data.out_last);
                    bad_cnt++;
                end
            end
        end
        out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // Main sequence
    initial
    begin
        in_item_t  it;
        out_item_t r0;
        out_item_t r1;
        int        n;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_ready      = 1'b0;
        hold_req       = 1'b0;
        bad_cnt        = 0;
        cycle_cnt      = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        tag_open       = 1'b0;
        held_lead      = 8'h00;
        held_ok        = 1'b0;
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows, hand expectations where given
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            it.in_byte = DIR_TBL[i].b;
            it.in_last = DIR_TBL[i].last;
            normalize_byte(it, n, r0, r1);
            if (DIR_TBL[i].known)
                queue_results(DIR_TBL[i].n, DIR_TBL[i].r0, DIR_TBL[i].r1);
            else
                queue_results(n, r0, r1);
            offer_byte(it);
        end

        // Random strings: back-pressure burst first, then idling mixes
        hold_req <= 1'b1;
        run_phase(0, 0, PHASE_ITEMS);
        run_phase(47, 0, PHASE_ITEMS);
        run_phase(0, 47, PHASE_ITEMS);
        run_phase(7, 7, PHASE_ITEMS);
        in_valid <= 1'b0;

        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (bad_cnt == 0 && pending_chars.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
